>>> design/smn_pkg.sv
// Shared types, codes and the opcode decoder for the narrowing move unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package smn_pkg;

  localparam int unsigned NumLanes = 4;

  typedef enum logic [1:0] {
    MODE_TRUNC,
    MODE_SSAT,
    MODE_USAT
  } mode_t;

  typedef enum logic [1:0] {
    WID_8,
    WID_16,
    WID_32,
    WID_64
  } width_t;

  // What one lane needs to narrow its value.
  typedef struct packed {
    mode_t  mode;
    width_t src_w;
    width_t dst_w;
  } lane_cfg_t;

  // Control that travels with a transaction to the merge stage.
  typedef struct packed {
    logic                valid;
    width_t              dst_w;
    logic [NumLanes-1:0] lanes_used;
    logic                mask_enable;
    logic                zero_masking;
    logic [NumLanes-1:0] mask_bits;
  } merge_ctrl_t;

  typedef struct packed {
    logic                ok;
    lane_cfg_t           cfg;
    logic [NumLanes-1:0] lanes_used;
  } decode_t;

  // Opcode is mode * 6 + size pair; size pairs wb, db, qb, dw, qw, qd.
  function automatic decode_t decode_op(input logic [4:0] op);
    decode_t     d;
    logic [4:0]  pair;
    d = '0;
    d.ok = 1'b1;
    if (op < 5'd6) begin
      d.cfg.mode = MODE_TRUNC;
      pair = op;
    end else if (op < 5'd12) begin
      d.cfg.mode = MODE_SSAT;
      pair = op - 5'd6;
    end else if (op < 5'd18) begin
      d.cfg.mode = MODE_USAT;
      pair = op - 5'd12;
    end else begin
      d.ok = 1'b0;
      d.cfg.mode = MODE_TRUNC;
      pair = '0;
    end
    case (pair[2:0])
      3'd0: begin d.cfg.src_w = WID_16; d.cfg.dst_w = WID_8;  d.lanes_used = 4'b1111; end
      3'd1: begin d.cfg.src_w = WID_32; d.cfg.dst_w = WID_8;  d.lanes_used = 4'b0011; end
      3'd2: begin d.cfg.src_w = WID_64; d.cfg.dst_w = WID_8;  d.lanes_used = 4'b0001; end
      3'd3: begin d.cfg.src_w = WID_32; d.cfg.dst_w = WID_16; d.lanes_used = 4'b0011; end
      3'd4: begin d.cfg.src_w = WID_64; d.cfg.dst_w = WID_16; d.lanes_used = 4'b0001; end
      3'd5: begin d.cfg.src_w = WID_64; d.cfg.dst_w = WID_32; d.lanes_used = 4'b0001; end
      default: begin
        d.cfg.src_w = WID_64;
        d.cfg.dst_w = WID_32;
        d.lanes_used = '0;
      end
    endcase
    if (!d.ok) begin
      d.lanes_used = '0;
    end
    return d;
  endfunction

endpackage

>>> design/smn_lane.sv
// One narrowing lane: truncation, signed or unsigned saturation of one source lane.
// Depends on smn_pkg.
`timescale 1ns / 1ps

module smn_lane
  import smn_pkg::*;
(
  input  lane_cfg_t   cfg,
  input  logic [63:0] lane_in,
  output logic [31:0] narrowed
);

  logic        [31:0] dmask;
  logic signed [64:0] sval;
  logic signed [64:0] dmax;
  logic signed [64:0] dmin;

  always_comb begin
    unique case (cfg.dst_w)
      WID_8:   begin dmask = 32'h0000_00FF; dmax = 65'sd127; end
      WID_16:  begin dmask = 32'h0000_FFFF; dmax = 65'sd32767; end
      default: begin dmask = 32'hFFFF_FFFF; dmax = 65'sd2147483647; end
    endcase
    dmin = -dmax - 65'sd1;
  end

  // Source lane as a signed value, sign-extended from its own width.
  always_comb begin
    unique case (cfg.src_w)
      WID_16:  sval = {{49{lane_in[15]}}, lane_in[15:0]};
      WID_32:  sval = {{33{lane_in[31]}}, lane_in[31:0]};
      default: sval = {lane_in[63], lane_in};
    endcase
  end

  always_comb begin
    case (cfg.mode)
      MODE_USAT: begin
        if (lane_in > {32'b0, dmask}) begin
          narrowed = dmask;
        end else begin
          narrowed = lane_in[31:0];
        end
      end
      MODE_SSAT: begin
        if (sval > dmax) begin
          narrowed = dmax[31:0];
        end else if (sval < dmin) begin
          narrowed = dmin[31:0] & dmask;
        end else begin
          narrowed = lane_in[31:0] & dmask;
        end
      end
      default: narrowed = lane_in[31:0] & dmask;
    endcase
  end

endmodule

>>> design/smn_merge.sv
// Merge stage: applies the opmask, packs the narrowed lanes and registers the result.
// Depends on smn_pkg.
`timescale 1ns / 1ps

module smn_merge
  import smn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  merge_ctrl_t ctrl,
  input  logic [31:0] lane_val [NumLanes],
  input  logic [31:0] old_destination,
  output logic [31:0] result_chunk,
  output logic        done
);

  logic [31:0] lane_out [NumLanes];
  logic [31:0] result_next;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      logic [31:0] old_field;
      case (ctrl.dst_w)
        WID_8:   old_field = {24'b0, old_destination[8*i +: 8]};
        WID_16:  old_field = {16'b0, 16'(old_destination >> (16 * i))};
        default: old_field = (i == 0) ? old_destination : 32'b0;
      endcase
      if (!ctrl.lanes_used[i]) begin
        lane_out[i] = '0;
      end else if (ctrl.mask_enable && !ctrl.mask_bits[i]) begin
        lane_out[i] = ctrl.zero_masking ? 32'b0 : old_field;
      end else begin
        lane_out[i] = lane_val[i];
      end
    end
  end

  always_comb begin
    case (ctrl.dst_w)
      WID_8: begin
        result_next = {lane_out[3][7:0], lane_out[2][7:0], lane_out[1][7:0], lane_out[0][7:0]};
      end
      WID_16:  result_next = {lane_out[1][15:0], lane_out[0][15:0]};
      default: result_next = lane_out[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      result_chunk <= result_next;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    ctrl.valid |=> done) else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !ctrl.valid |=> !done) else $error("result strobe without a transaction");

  a_bad_op_zero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.valid && ctrl.lanes_used == 4'b0000) |=> (result_chunk == 32'b0))
    else $error("undefined opcode gave a nonzero result");

  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    (ctrl.valid && ctrl.lanes_used == 4'b0001 && ctrl.dst_w == WID_8)
    |=> (result_chunk[31:8] == 24'b0))
    else $error("unused high result bits not cleared");

endmodule

>>> design/simd_narrowing_move_unit.sv
// Top level of the packed narrowing move unit: opcode decode, four lanes, merge stage.
// Depends on smn_pkg, smn_lane and smn_merge.
`timescale 1ns / 1ps

// Narrows one 64-bit source chunk per transaction. A transaction is accepted on
// any clock edge where start is high; busy is never raised, so one transaction
// can enter every cycle. The result appears on result_chunk with done high for
// exactly one cycle, the cycle after acceptance, set by the single output register
// of the merge stage. The receiver cannot stall the unit and must take each result
// in the cycle it is shown.
module simd_narrowing_move_unit
  import smn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  opcode,
  input  logic [63:0] source_chunk,
  input  logic [3:0]  mask_bits,
  input  logic        mask_enable,
  input  logic        zero_masking,
  input  logic [31:0] old_destination,
  output logic [31:0] result_chunk,
  output logic        done
);

  decode_t     dec;
  merge_ctrl_t ctrl;
  logic [63:0] lane_in  [NumLanes];
  logic [31:0] lane_val [NumLanes];

  assign busy = 1'b0;
  assign dec  = decode_op(opcode);

  assign ctrl.valid        = start && !busy;
  assign ctrl.dst_w        = dec.cfg.dst_w;
  assign ctrl.lanes_used   = dec.lanes_used;
  assign ctrl.mask_enable  = mask_enable;
  assign ctrl.zero_masking = zero_masking;
  assign ctrl.mask_bits    = mask_bits;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    logic [31:0] word_sel;
    if (i < 2) begin : g_word
      assign word_sel = source_chunk[32*i +: 32];
    end else begin : g_noword
      assign word_sel = '0;
    end

    always_comb begin
      case (dec.cfg.src_w)
        WID_16:  lane_in[i] = {48'b0, source_chunk[16*i +: 16]};
        WID_32:  lane_in[i] = {32'b0, word_sel};
        default: lane_in[i] = (i == 0) ? source_chunk : 64'b0;
      endcase
    end

    smn_lane u_lane (
      .cfg      (dec.cfg),
      .lane_in  (lane_in[i]),
      .narrowed (lane_val[i])
    );
  end

  smn_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .lane_val        (lane_val),
    .old_destination (old_destination),
    .result_chunk    (result_chunk),
    .done            (done)
  );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for simd_narrowing_move_unit: directed edge cases, then bursty random
// traffic, with every result compared against an in-bench model of the narrowing rules.
// Depends on smn_pkg and the simd_narrowing_move_unit RTL.
`timescale 1ns / 1ps

module tb
  import smn_pkg::*;
();

  typedef enum logic [2:0] {
    PAIR_WB,
    PAIR_DB,
    PAIR_QB,
    PAIR_DW,
    PAIR_QW,
    PAIR_QD
  } size_pair_e;

  localparam int unsigned PAIRS_PER_MODE = 6;
  localparam logic [4:0] OP_FIRST_UNUSED = 5'd18;
  localparam logic [4:0] OP_LAST = 5'd31;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned MAX_REPORTS = 200;

  typedef struct {
    logic [4:0]  op;
    logic [63:0] src;
    logic [3:0]  mbits;
    logic        men;
    logic        zm;
    logic [31:0] old;
  } chunk_req_t;

  typedef struct {
    logic [4:0]  op;
    logic [31:0] value;
  } expected_chunk_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [4:0]  opcode;
  logic [63:0] source_chunk;
  logic [3:0]  mask_bits;
  logic        mask_enable;
  logic        zero_masking;
  logic [31:0] old_destination;
  logic [31:0] result_chunk;
  logic        done;

  expected_chunk_t expected_chunks[$];
  int unsigned     mismatch_count;

  simd_narrowing_move_unit uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .source_chunk   (source_chunk),
    .mask_bits      (mask_bits),
    .mask_enable    (mask_enable),
    .zero_masking   (zero_masking),
    .old_destination(old_destination),
    .result_chunk   (result_chunk),
    .done           (done)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  function automatic logic [4:0] op_code(input mode_t m, input size_pair_e p);
    logic [4:0] mv;
    logic [4:0] pv;
    mv = 5'(m);
    pv = 5'(p);
    return mv * 5'd6 + pv;
  endfunction

  function automatic void pair_widths(input size_pair_e p, output int unsigned sbits,
                                      output int unsigned dbits);
    case (p)
      PAIR_WB: begin sbits = 16; dbits = 8;  end
      PAIR_DB: begin sbits = 32; dbits = 8;  end
      PAIR_QB: begin sbits = 64; dbits = 8;  end
      PAIR_DW: begin sbits = 32; dbits = 16; end
      PAIR_QW: begin sbits = 64; dbits = 16; end
      default: begin sbits = 64; dbits = 32; end
    endcase
  endfunction

  // Narrows every lane of the chunk, then applies merge or zero masking per lane.
  function automatic logic [31:0] narrow_chunk(input chunk_req_t r);
    logic [1:0]         mode_idx;
    mode_t              mode;
    size_pair_e         pair;
    int unsigned        sbits;
    int unsigned        dbits;
    int unsigned        lanes;
    int unsigned        i;
    logic [63:0]        smask;
    logic [63:0]        dmask;
    logic [63:0]        lane;
    logic [63:0]        val;
    logic [63:0]        acc;
    longint             sval;
    longint             smax;
    longint             smin;
    if (r.op >= OP_FIRST_UNUSED) begin
      return '0;
    end
    mode_idx = 2'(r.op / 5'd6);
    mode = mode_t'(mode_idx);
    pair = size_pair_e'(3'(r.op % 5'd6));
    pair_widths(pair, sbits, dbits);
    lanes = 64 / sbits;
    smask = (sbits == 64) ? '1 : ((64'd1 << sbits) - 64'd1);
    dmask = (64'd1 << dbits) - 64'd1;
    acc = '0;
    for (i = 0; i < lanes; i++) begin
      lane = (r.src >> (i * sbits)) & smask;
      case (mode)
        MODE_TRUNC: val = lane & dmask;
        MODE_USAT: val = (lane > dmask) ? dmask : lane;
        default: begin
          sval = signed'(lane << (64 - sbits)) >>> (64 - sbits);
          smax = (64'sd1 <<< (dbits - 1)) - 64'sd1;
          smin = -smax - 64'sd1;
          if (sval > smax) begin
            val = smax & dmask;
          end else if (sval < smin) begin
            val = smin & dmask;
          end else begin
            val = lane & dmask;
          end
        end
      endcase
      if (r.men && !r.mbits[i]) begin
        val = r.zm ? '0 : ((64'(r.old) >> (i * dbits)) & dmask);
      end
      acc = acc | ((val & dmask) << (i * dbits));
    end
    return acc[31:0];
  endfunction

  // Lanes cluster around the clamp limits of the result and the sign limits of the source.
  function automatic logic [63:0] random_source(input logic [4:0] op);
    size_pair_e  pair;
    int unsigned sbits;
    int unsigned dbits;
    int unsigned i;
    logic [63:0] smask;
    logic [63:0] base;
    logic [63:0] src;
    if (op >= OP_FIRST_UNUSED || $urandom_range(0, 3) == 0) begin
      return {$urandom, $urandom};
    end
    pair = size_pair_e'(3'(op % 5'd6));
    pair_widths(pair, sbits, dbits);
    smask = (sbits == 64) ? '1 : ((64'd1 << sbits) - 64'd1);
    src = '0;
    for (i = 0; i < 64 / sbits; i++) begin
      case ($urandom_range(0, 6))
        0: base = '0;
        1: base = (64'd1 << dbits) - 64'd1;
        2: base = (64'd1 << (dbits - 1)) - 64'd1;
        3: base = ~((64'd1 << (dbits - 1)) - 64'd1);
        4: base = smask >> 1;
        5: base = ~(smask >> 1);
        default: base = {$urandom, $urandom};
      endcase
      base = base + 64'($urandom_range(0, 2)) - 64'd1;
      src = src | ((base & smask) << (i * sbits));
    end
    return src;
  endfunction

  function automatic chunk_req_t random_chunk();
    chunk_req_t r;
    if ($urandom_range(0, 19) == 0) begin
      r.op = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST));
    end else begin
      r.op = 5'($urandom_range(0, OP_FIRST_UNUSED - 1));
    end
    r.src = random_source(r.op);
    r.mbits = 4'($urandom);
    r.men = 1'($urandom);
    r.zm = 1'($urandom);
    r.old = $urandom;
    return r;
  endfunction

  function automatic chunk_req_t make_chunk(input logic [4:0] op, input logic [63:0] src,
                                            input logic [3:0] mbits, input logic men,
                                            input logic zm, input logic [31:0] old);
    chunk_req_t r;
    r.op = op;
    r.src = src;
    r.mbits = mbits;
    r.men = men;
    r.zm = zm;
    r.old = old;
    return r;
  endfunction

  // Leaves start high on return so that the next transaction can follow back to back.
  task automatic send_chunk(input chunk_req_t r);
    @(negedge clk);
    start = 1'b1;
    opcode = r.op;
    source_chunk = r.src;
    mask_bits = r.mbits;
    mask_enable = r.men;
    zero_masking = r.zm;
    old_destination = r.old;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
  endtask

  // While idle the data fields carry junk that must be ignored.
  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      start = 1'b0;
      opcode = 5'($urandom);
      source_chunk = {$urandom, $urandom};
      old_destination = $urandom;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start = 1'b0;
    while (expected_chunks.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    expected_chunk_t exp_chunk;
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_chunks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result: expected none, actual result_chunk %h",
                     $time, result_chunk);
          end
        end else begin
          exp_chunk = expected_chunks.pop_front();
          if (result_chunk !== exp_chunk.value) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: result_chunk mismatch, opcode %0d: expected %h, actual %h",
                       $time, exp_chunk.op, exp_chunk.value, result_chunk);
            end
          end
        end
      end else if (done !== 1'b0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: done mismatch: expected 0 or 1, actual %b", $time, done);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        exp_chunk.op = opcode;
        exp_chunk.value = narrow_chunk(make_chunk(opcode, source_chunk, mask_bits,
                                                  mask_enable, zero_masking,
                                                  old_destination));
        expected_chunks.push_back(exp_chunk);
      end
    end
  end

  // Every mode over every size pair, with lanes sitting on and just past the clamp limits.
  task automatic test_narrowing_extremes();
    mode_t       modes[3];
    logic [63:0] src;
    int unsigned m;
    int unsigned p;
    modes = '{MODE_TRUNC, MODE_SSAT, MODE_USAT};
    for (m = 0; m < 3; m++) begin
      for (p = 0; p < PAIRS_PER_MODE; p++) begin
        case (size_pair_e'(3'(p)))
          PAIR_WB: src = 64'h8000_7FFF_FF80_0100;
          PAIR_DB: src = 64'h8000_0000_0000_00FF;
          PAIR_QB: src = 64'hFFFF_FFFF_FFFF_FF7F;
          PAIR_DW: src = 64'h0001_0000_FFFF_8000;
          PAIR_QW: src = 64'h8000_0000_0000_0000;
          default: src = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
        send_chunk(make_chunk(op_code(modes[m], size_pair_e'(3'(p))), src, 4'hF, 1'b0,
                              1'b0, 32'hFFFF_FFFF));
      end
    end
  endtask

  task automatic test_masking_cases();
    // Merge keeps old bytes in lanes 1 and 3.
    send_chunk(make_chunk(op_code(MODE_SSAT, PAIR_WB), 64'h1234_8000_7FFF_0042, 4'b0101,
                          1'b1, 1'b0, 32'hA5C3_9E71));
    // Zero masking clears lane 0 only.
    send_chunk(make_chunk(op_code(MODE_USAT, PAIR_DB), 64'hFFFF_FFFF_0000_00FF, 4'b0010,
                          1'b1, 1'b1, 32'hFFFF_FFFF));
    // With masking off, mask bits and zero masking are ignored.
    send_chunk(make_chunk(op_code(MODE_TRUNC, PAIR_QD), 64'hDEAD_BEEF_CAFE_F00D, 4'b0000,
                          1'b0, 1'b1, 32'h1111_1111));
    // A single lane masked off merges only its own byte; mask bits of missing lanes and
    // old bits above the lane are ignored.
    send_chunk(make_chunk(op_code(MODE_USAT, PAIR_QB), 64'h0000_0000_0000_1000, 4'b1110,
                          1'b1, 1'b0, 32'hFFFF_FF5A));
  endtask

  task automatic test_unused_opcodes();
    send_chunk(make_chunk(OP_FIRST_UNUSED, '1, 4'hF, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_chunk(make_chunk(OP_LAST, '1, 4'h0, 1'b1, 1'b0, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_traffic(input int unsigned items);
    int unsigned sent;
    int unsigned burst_left;
    sent = 0;
    burst_left = 0;
    while (sent < items) begin
      if (burst_left == 0) begin
        idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
        burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
      end
      send_chunk(random_chunk());
      burst_left--;
      sent++;
      // Halfway through, hold off until the unit has handed back everything.
      if (sent == items / 2) begin
        wait_results_drained();
      end
    end
  endtask

  initial begin
    int unsigned guard;
    mismatch_count = 0;
    rst = 1'b1;
    start = 1'b0;
    opcode = '0;
    source_chunk = '0;
    mask_bits = '0;
    mask_enable = 1'b0;
    zero_masking = 1'b0;
    old_destination = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_narrowing_extremes();
    test_masking_cases();
    test_unused_opcodes();
    wait_results_drained();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk);
    start = 1'b0;
    guard = 0;
    while (expected_chunks.size() != 0 && guard < 100) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
    if (expected_chunks.size() != 0) begin
      mismatch_count++;
      $display("%0t: missing results: expected %0d more, actual 0", $time,
               expected_chunks.size());
    end
    if (mismatch_count == 0) begin
      $display("PASS simd_narrowing_move_unit");
    end else begin
      $display("FAIL simd_narrowing_move_unit");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL simd_narrowing_move_unit");
    $finish;
  end

endmodule
